// ----- rtl/core/zbom_pkg.sv -----
package zbom_pkg;

    // default buffer geometry, handed to the top-level parameters
    localparam int MAX_COLOR_WIDTH_DEF  = 1024;
    localparam int MAX_COLOR_HEIGHT_DEF = 512;
    // indexes at or above this never touch the buffers
    localparam int MAX_POINTS           = 524288;

    localparam int IDX_W   = 19;
    localparam int DEPTH_W = 16;
    localparam int COORD_W = 16;
    localparam int CW_W    = 11;
    localparam int CH_W    = 10;
    localparam int CFG_W   = 11;

    localparam int S_TDATA_W = 72;
    localparam int M_TDATA_W = 24;
    localparam int M_TUSER_W = 2;

    // frame generation tag kept beside each buffer entry; tag 0 means cleared
    localparam int EPOCH_W = 8;
    localparam logic [EPOCH_W-1:0] EPOCH_LAST  = '1;
    localparam logic [EPOCH_W-1:0] EPOCH_CLEAR = '0;
    localparam logic [EPOCH_W-1:0] EPOCH_FIRST = EPOCH_W'(1);

    localparam int QUEUE_DEPTH = 4;

    localparam logic [CW_W-1:0] RESET_COLOR_WIDTH  = CW_W'(640);
    localparam logic [CH_W-1:0] RESET_COLOR_HEIGHT = CH_W'(480);

    localparam logic [0:0] REG_COLOR_WIDTH  = 1'b0;
    localparam logic [0:0] REG_COLOR_HEIGHT = 1'b1;

    localparam logic [1:0] KIND_PASS  = 2'd0;  // no buffer access, empty result
    localparam logic [1:0] KIND_OP    = 2'd1;  // depth test at one pixel
    localparam logic [1:0] KIND_SWEEP = 2'd2;  // clear the whole buffer, no result

    typedef struct packed {
        logic [1:0]         kind;
        logic [EPOCH_W-1:0] epoch;
        logic [DEPTH_W-1:0] depth;
        logic [IDX_W-1:0]   idx;
    } t_cmd;

    typedef struct packed {
        logic [DEPTH_W-1:0] depth;
        logic [EPOCH_W-1:0] epoch;
        logic [IDX_W-1:0]   owner;
    } t_word;

endpackage

// ----- rtl/core/zbom_ram.sv -----
module zbom_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/core/zbom_queue.sv -----
module zbom_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic             o_valid,
    output logic [WIDTH-1:0] o_data
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_slot [DEPTH];
    logic [PW-1:0]    r_wptr, n_wptr;
    logic [PW-1:0]    r_rptr, n_rptr;
    logic [CW-1:0]    r_count, n_count;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_data  = r_slot[r_rptr];

    always_comb begin
        n_wptr  = r_wptr;
        n_rptr  = r_rptr;
        n_count = r_count;
        if (i_push) begin
            n_wptr = (r_wptr == PW'(DEPTH - 1)) ? '0 : r_wptr + 1'b1;
        end
        if (i_pop) begin
            n_rptr = (r_rptr == PW'(DEPTH - 1)) ? '0 : r_rptr + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (i_pop && !i_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wptr] <= i_data;
        end
    end

endmodule

// ----- rtl/core/zbom_front.sv -----
module zbom_front #(
    parameter int MAX_COLOR_WIDTH  = zbom_pkg::MAX_COLOR_WIDTH_DEF,
    parameter int MAX_COLOR_HEIGHT = zbom_pkg::MAX_COLOR_HEIGHT_DEF,
    parameter int AW               = $clog2(MAX_COLOR_WIDTH * MAX_COLOR_HEIGHT)
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [0:0]                     i_cfg_index,
    input  logic [zbom_pkg::CFG_W-1:0]     i_cfg_data,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    input  logic [zbom_pkg::S_TDATA_W-1:0] s_axis_tdata,
    input  logic                           s_axis_tuser,
    input  logic                           i_hold,
    input  logic                           i_q_full,
    output logic                           o_q_push,
    output zbom_pkg::t_cmd                 o_q_cmd,
    output logic [AW-1:0]                  o_q_addr
);

    localparam int XW = $clog2(MAX_COLOR_WIDTH);
    localparam int YW = $clog2(MAX_COLOR_HEIGHT);

    logic [zbom_pkg::CW_W-1:0]    r_cw;
    logic [zbom_pkg::CH_W-1:0]    r_ch;
    logic [zbom_pkg::EPOCH_W-1:0] r_epoch;

    logic [zbom_pkg::IDX_W-1:0]   in_idx;
    logic [zbom_pkg::DEPTH_W-1:0] in_depth;
    logic [zbom_pkg::COORD_W-1:0] in_x;
    logic [zbom_pkg::COORD_W-1:0] in_y;
    logic [zbom_pkg::CW_W-1:0]    w_eff;
    logic [zbom_pkg::CH_W-1:0]    h_eff;
    logic                         x_ok, y_ok, idx_ok, do_op;
    logic                         ready_base, sweep_req, accept;
    logic [zbom_pkg::EPOCH_W-1:0] epoch_next;

    assign in_idx   = s_axis_tdata[18:0];
    assign in_depth = s_axis_tdata[34:19];
    assign in_x     = s_axis_tdata[50:35];
    assign in_y     = s_axis_tdata[66:51];

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cw <= zbom_pkg::RESET_COLOR_WIDTH;
            r_ch <= zbom_pkg::RESET_COLOR_HEIGHT;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                zbom_pkg::REG_COLOR_WIDTH: begin
                    r_cw <= i_cfg_data[zbom_pkg::CW_W-1:0];
                end
                zbom_pkg::REG_COLOR_HEIGHT: begin
                    r_ch <= i_cfg_data[zbom_pkg::CH_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // oversized registers saturate to the buffer geometry
    assign w_eff = (32'(r_cw) > 32'(MAX_COLOR_WIDTH)) ?
                   zbom_pkg::CW_W'(MAX_COLOR_WIDTH) : r_cw;
    assign h_eff = (32'(r_ch) > 32'(MAX_COLOR_HEIGHT)) ?
                   zbom_pkg::CH_W'(MAX_COLOR_HEIGHT) : r_ch;

    assign x_ok   = !in_x[zbom_pkg::COORD_W-1] && (in_x < zbom_pkg::COORD_W'(w_eff));
    assign y_ok   = !in_y[zbom_pkg::COORD_W-1] && (in_y < zbom_pkg::COORD_W'(h_eff));
    assign idx_ok = 32'(in_idx) < 32'(zbom_pkg::MAX_POINTS);
    assign do_op  = (in_depth != '0) && idx_ok && x_ok && y_ok;

    // a frame start on the last generation tag first sends a full clear
    assign ready_base    = !i_hold && !i_q_full;
    assign sweep_req     = s_axis_tuser && (r_epoch == zbom_pkg::EPOCH_LAST);
    assign s_axis_tready = ready_base && !sweep_req;
    assign o_q_push      = s_axis_tvalid && ready_base;
    assign accept        = o_q_push && !sweep_req;
    assign epoch_next    = s_axis_tuser ? r_epoch + 1'b1 : r_epoch;

    always_comb begin
        o_q_cmd.epoch = epoch_next;
        o_q_cmd.depth = in_depth;
        o_q_cmd.idx   = in_idx;
        if (sweep_req) begin
            o_q_cmd.kind = zbom_pkg::KIND_SWEEP;
        end else if (do_op) begin
            o_q_cmd.kind = zbom_pkg::KIND_OP;
        end else begin
            o_q_cmd.kind = zbom_pkg::KIND_PASS;
        end
    end

    assign o_q_addr = AW'(32'(in_y[YW-1:0]) * 32'(MAX_COLOR_WIDTH) + 32'(in_x[XW-1:0]));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_epoch <= zbom_pkg::EPOCH_FIRST;
        end else if (o_q_push && sweep_req) begin
            r_epoch <= zbom_pkg::EPOCH_CLEAR;
        end else if (accept) begin
            r_epoch <= epoch_next;
        end
    end

endmodule

// ----- rtl/core/zbom_back.sv -----
module zbom_back #(
    parameter int ENTRIES = zbom_pkg::MAX_COLOR_WIDTH_DEF * zbom_pkg::MAX_COLOR_HEIGHT_DEF,
    parameter int AW      = $clog2(ENTRIES)
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_q_valid,
    input  zbom_pkg::t_cmd                 i_q_cmd,
    input  logic [AW-1:0]                  i_q_addr,
    output logic                           o_q_pop,
    output logic                           o_busy,
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    output logic [zbom_pkg::M_TDATA_W-1:0] m_axis_tdata,
    output logic [zbom_pkg::M_TUSER_W-1:0] m_axis_tuser
);

    localparam int WW = $bits(zbom_pkg::t_word);

    logic                       r_s1_valid;
    zbom_pkg::t_cmd             r_s1_cmd;
    logic [AW-1:0]              r_s1_addr;
    logic [AW-1:0]              r_sweep_cnt;
    logic                       r_byp_valid;
    logic [AW-1:0]              r_byp_addr;
    zbom_pkg::t_word            r_byp_data;
    logic                       r_out_valid;
    logic [zbom_pkg::IDX_W-1:0] r_out_idx;
    logic                       r_out_mark;
    logic                       r_out_cur;

    logic                         s1_sweep, sweep_done, out_free, s1_adv, item_fire;
    zbom_pkg::t_word              ram_q, cur_word, wr_word;
    logic [WW-1:0]                ram_rdata;
    logic [zbom_pkg::DEPTH_W-1:0] stored;
    logic                         we;
    logic [AW-1:0]                waddr;
    logic                         n_mark, n_cur;
    logic [zbom_pkg::IDX_W-1:0]   n_idx;

    assign s1_sweep   = r_s1_valid && (r_s1_cmd.kind == zbom_pkg::KIND_SWEEP);
    assign sweep_done = s1_sweep && (r_sweep_cnt == AW'(ENTRIES - 1));
    assign out_free   = !r_out_valid || m_axis_tready;
    assign s1_adv     = !r_s1_valid || (s1_sweep ? sweep_done : out_free);
    assign item_fire  = r_s1_valid && !s1_sweep && out_free;
    assign o_q_pop    = s1_adv && i_q_valid;
    assign o_busy     = s1_sweep;

    zbom_ram #(
        .WIDTH (WW),
        .DEPTH (ENTRIES)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wr_word),
        .i_re    (o_q_pop),
        .i_raddr (i_q_addr),
        .o_rdata (ram_rdata)
    );

    assign ram_q = ram_rdata;

    // the last write is always the newest content of its address
    assign cur_word = (r_byp_valid && (r_byp_addr == r_s1_addr)) ? r_byp_data : ram_q;
    // an entry from an older frame reads as empty
    assign stored   = (cur_word.epoch == r_s1_cmd.epoch) ? cur_word.depth : '0;

    always_comb begin
        we            = 1'b0;
        waddr         = r_s1_addr;
        wr_word.depth = r_s1_cmd.depth;
        wr_word.epoch = r_s1_cmd.epoch;
        wr_word.owner = r_s1_cmd.idx;
        n_mark        = 1'b0;
        n_cur         = 1'b0;
        n_idx         = '0;
        case (r_s1_cmd.kind)
            zbom_pkg::KIND_SWEEP: begin
                we            = r_s1_valid;
                waddr         = r_sweep_cnt;
                wr_word.depth = '0;
                wr_word.epoch = zbom_pkg::EPOCH_CLEAR;
                wr_word.owner = '0;
            end
            zbom_pkg::KIND_OP: begin
                if (stored == '0) begin
                    we = item_fire;
                end else if (stored <= r_s1_cmd.depth) begin
                    n_mark = 1'b1;
                    n_cur  = 1'b1;
                    n_idx  = r_s1_cmd.idx;
                end else begin
                    we     = item_fire;
                    n_mark = 1'b1;
                    n_idx  = cur_word.owner;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            // reset starts with a clearing pass over the whole buffer
            r_s1_valid    <= 1'b1;
            r_s1_cmd.kind <= zbom_pkg::KIND_SWEEP;
            r_sweep_cnt   <= '0;
            r_byp_valid   <= 1'b0;
            r_out_valid   <= 1'b0;
        end else begin
            if (s1_adv) begin
                r_s1_valid <= i_q_valid;
                r_s1_cmd   <= i_q_cmd;
            end
            if (sweep_done) begin
                r_sweep_cnt <= '0;
            end else if (s1_sweep) begin
                r_sweep_cnt <= r_sweep_cnt + 1'b1;
            end
            if (we) begin
                r_byp_valid <= 1'b1;
            end
            if (item_fire) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv) begin
            r_s1_addr <= i_q_addr;
        end
        if (we) begin
            r_byp_addr <= waddr;
            r_byp_data <= wr_word;
        end
        if (item_fire) begin
            r_out_idx  <= n_idx;
            r_out_mark <= n_mark;
            r_out_cur  <= n_cur;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = zbom_pkg::M_TDATA_W'(r_out_idx);
    assign m_axis_tuser  = {r_out_cur, r_out_mark};

endmodule

// ----- rtl/core/zbom_queue_note.sv -----
module zbom_qcount #(
    parameter int DEPTH = 4
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  logic i_pop,
    output logic o_over
);

    localparam int CW = $clog2(DEPTH + 2);

    logic [CW-1:0] r_level;

    // independent occupancy count, flags a push beyond the queue depth
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_level <= '0;
        end else if (i_push && !i_pop) begin
            r_level <= r_level + 1'b1;
        end else if (i_pop && !i_push) begin
            r_level <= r_level - 1'b1;
        end
    end

    assign o_over = (r_level > CW'(DEPTH));

endmodule

// ----- rtl/core/zbuffer_occlusion_marker.sv -----
// Z-buffer occlusion marker: takes one projected depth point per cycle and returns one result
// per point, in order. A point with nonzero depth inside the configured image is tested against
// a depth/owner buffer of MAX_COLOR_WIDTH x MAX_COLOR_HEIGHT entries (addressed y*MAX_W + x);
// the farther point is reported as occluded (the current one on equal depth) and the nearer one
// owns the pixel. Throughput is one item per cycle unless the output stalls or a clearing pass
// runs, set by the single read-modify-write per item on the buffer RAM (one write and one
// registered read port, with a write bypass); a result passes through the queue, the read stage
// and the output register. Frame clears use an 8-bit generation tag stored with each entry, so
// first_of_frame costs nothing, except that every 255th frame start runs a full clearing pass
// over all MAX_W*MAX_H entries (524288 with defaults) ahead of that item, with input held off
// while the pass runs. The same pass runs after reset, with input held off. Configuration may be
// written at any time the block is idle; width and height above the buffer geometry saturate.
module zbuffer_occlusion_marker #(
    parameter int MAX_COLOR_WIDTH  = zbom_pkg::MAX_COLOR_WIDTH_DEF,
    parameter int MAX_COLOR_HEIGHT = zbom_pkg::MAX_COLOR_HEIGHT_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [0:0]                     i_cfg_index,   // 0 color_width, 1 color_height
    input  logic [zbom_pkg::CFG_W-1:0]     i_cfg_data,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    // point_index[18:0], depth_mm[34:19], pix_x[50:35], pix_y[66:51], zero fill
    input  logic [zbom_pkg::S_TDATA_W-1:0] s_axis_tdata,
    input  logic                           s_axis_tuser,  // first_of_frame
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // occluded_index[18:0], zero fill
    output logic [zbom_pkg::M_TDATA_W-1:0] m_axis_tdata,
    // mark_valid[0], marked_is_current[1]
    output logic [zbom_pkg::M_TUSER_W-1:0] m_axis_tuser
);

    localparam int ENTRIES = MAX_COLOR_WIDTH * MAX_COLOR_HEIGHT;
    localparam int AW      = $clog2(ENTRIES);
    localparam int QW      = $bits(zbom_pkg::t_cmd) + AW;

    logic           q_push, q_full, q_pop, q_valid, busy, q_over;
    zbom_pkg::t_cmd f_cmd, b_cmd;
    logic [AW-1:0]  f_addr, b_addr;
    logic [QW-1:0]  q_out;

    zbom_front #(
        .MAX_COLOR_WIDTH  (MAX_COLOR_WIDTH),
        .MAX_COLOR_HEIGHT (MAX_COLOR_HEIGHT),
        .AW               (AW)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .i_hold        (busy),
        .i_q_full      (q_full),
        .o_q_push      (q_push),
        .o_q_cmd       (f_cmd),
        .o_q_addr      (f_addr)
    );

    zbom_queue #(
        .WIDTH (QW),
        .DEPTH (zbom_pkg::QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  ({f_cmd, f_addr}),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_data  (q_out)
    );

    assign b_cmd  = q_out[QW-1:AW];
    assign b_addr = q_out[AW-1:0];

    zbom_back #(
        .ENTRIES (ENTRIES),
        .AW      (AW)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_q_valid     (q_valid),
        .i_q_cmd       (b_cmd),
        .i_q_addr      (b_addr),
        .o_q_pop       (q_pop),
        .o_busy        (busy),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    zbom_qcount #(
        .DEPTH (zbom_pkg::QUEUE_DEPTH)
    ) u_qcount (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_pop   (q_pop),
        .o_over  (q_over)
    );

    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_push |-> (!q_full || q_pop))
        else $error("queue push while full");

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !q_over)
        else $error("queue occupancy beyond depth");

    a_busy_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        busy |-> !s_axis_tready)
        else $error("input taken during clearing pass");

    a_empty_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tuser[0]) |-> (m_axis_tdata == '0 && !m_axis_tuser[1]))
        else $error("result without mark carries data");

endmodule
